@@ sv/mx_pkg.sv @@
// ----------------------------------------------------------------------------
// mx_pkg
// Shared types for the modular exponentiation block: request and response
// payloads and the status bundle between the core and the top level.
// ----------------------------------------------------------------------------
package mx_pkg;

  // width of the base, exponent, modulus and result fields on the ports
  localparam int DATA_W = 64;

  // request payload
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] modulus;
  } mx_in_t;

  // response payload
  typedef struct packed {
    logic [DATA_W-1:0] power_result;
    logic              bad_modulus;
  } mx_out_t;

  // core status seen by the top level
  typedef struct packed {
    logic idle;
    logic done;
  } mx_stat_t;

endpackage

@@ sv/mx_addmod.sv @@
// ----------------------------------------------------------------------------
// mx_addmod
// Shared modular adder: (x + y + cin) mod m for x, y < m, by one add and
// one conditional subtract. Serves remainder steps, additions and doublings.
// ----------------------------------------------------------------------------
module mx_addmod #(
  parameter int W = 64
) (
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic         cin,
  input  logic [W-1:0] m,
  output logic [W-1:0] r
);

  logic [W:0] sum;
  logic [W:0] diff;

  // sum keeps its carry so the compare stays exact
  assign sum  = {1'b0, x} + {1'b0, y} + {{W{1'b0}}, cin};
  assign diff = sum - {1'b0, m};
  assign r    = (sum >= {1'b0, m}) ? diff[W-1:0] : sum[W-1:0];

endmodule

@@ sv/mx_core.sv @@
// ----------------------------------------------------------------------------
// mx_core
// Sequencer and operand registers for square-and-multiply. Reduces the base
// by shift-subtract, then runs shift-and-add modular products, all on one
// shared modular adder.
// ----------------------------------------------------------------------------
module mx_core #(
  parameter int W = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mx_pkg::mx_in_t   req,
  input  logic             take,
  output mx_pkg::mx_stat_t stat,
  output mx_pkg::mx_out_t  res
);
  import mx_pkg::*;

  localparam int CW = $clog2(W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_EXP,
    S_MUL_ADD,
    S_MUL_DBL,
    S_DONE
  } state_t;

  state_t        state;
  logic [W-1:0]  m_r;
  logic [W-1:0]  e_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  x_r;
  logic [W-1:0]  y_r;
  logic [W-1:0]  p_r;
  logic [CW-1:0] cnt;
  logic          sq;
  logic [W-1:0]  res_r;
  logic          bad_r;

  logic [W-1:0]  ux;
  logic [W-1:0]  uy;
  logic          uc;
  logic [W-1:0]  ur;

  // operand select for the shared adder
  always_comb begin
    ux = x_r;
    uy = x_r;
    uc = 1'b0;
    case (state)
      S_MOD: begin
        ux = p_r;
        uy = p_r;
        uc = y_r[W-1];
      end
      S_MUL_ADD: begin
        if (y_r[0]) begin
          ux = p_r;
          uy = x_r;
        end
      end
      default: ;
    endcase
  end

  mx_addmod #(.W(W)) u_addmod (
    .x   (ux),
    .y   (uy),
    .cin (uc),
    .m   (m_r),
    .r   (ur)
  );

  // sequencer and operand registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            m_r <= req.modulus[W-1:0];
            e_r <= req.exponent[W-1:0];
            y_r <= req.base[W-1:0];
            p_r <= '0;
            cnt <= CW'(W - 1);
            if (req.modulus[W-1:0] == '0) begin
              res_r <= '0;
              bad_r <= 1'b1;
              state <= S_DONE;
            end else if (req.exponent[W-1:0] == '0) begin
              res_r <= {{(W-1){1'b0}}, 1'b1};
              bad_r <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_MOD;
            end
          end
        end
        // base mod modulus, one base bit per cycle from the top
        S_MOD: begin
          p_r <= ur;
          y_r <= y_r << 1;
          if (cnt == '0) begin
            b_r   <= ur;
            a_r   <= {{(W-1){1'b0}}, 1'b1};
            state <= S_EXP;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        // pick the next product for the current exponent bit, or finish
        S_EXP: begin
          x_r <= b_r;
          p_r <= '0;
          if (e_r == '0) begin
            res_r <= a_r;
            bad_r <= 1'b0;
            state <= S_DONE;
          end else if (e_r[0]) begin
            y_r   <= a_r;
            sq    <= 1'b0;
            state <= S_MUL_ADD;
          end else begin
            y_r   <= b_r;
            sq    <= 1'b1;
            state <= S_MUL_ADD;
          end
        end
        // product step: add on a set bit, else double; store when done
        S_MUL_ADD: begin
          if (y_r == '0) begin
            if (!sq) begin
              a_r <= p_r;
              if (e_r[W-1:1] == '0) begin
                res_r <= p_r;
                bad_r <= 1'b0;
                state <= S_DONE;
              end else begin
                x_r <= b_r;
                y_r <= b_r;
                p_r <= '0;
                sq  <= 1'b1;
              end
            end else begin
              b_r   <= p_r;
              e_r   <= e_r >> 1;
              state <= S_EXP;
            end
          end else if (y_r[0]) begin
            p_r   <= ur;
            state <= S_MUL_DBL;
          end else begin
            x_r <= ur;
            y_r <= y_r >> 1;
          end
        end
        // product step: double the multiplicand
        S_MUL_DBL: begin
          x_r   <= ur;
          y_r   <= y_r >> 1;
          state <= S_MUL_ADD;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle        = (state == S_IDLE);
  assign stat.done        = (state == S_DONE);
  assign res.power_result = DATA_W'(res_r);
  assign res.bad_modulus  = bad_r;

endmodule

@@ sv/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus by right-to-left square-and-multiply, with
// shift-and-add modular products on a single modular adder.
//
//   channel   signals                       payload
//   request   req_valid / req_ready / req   base, exponent, modulus
//   response  rsp_valid / rsp_ready / rsp   power_result, bad_modulus
//
// A zero modulus or zero exponent finishes straight from the idle state.
// Otherwise the base is first reduced bit by bit, then each exponent bit
// up to the top set one is picked and costs one product when set plus one
// squaring (none after the top bit), each product by shift-and-add on the
// shared adder.
// Reset clears the sequencer and the response valid. A stalled response
// holds in its register; the next request is taken once the core is idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  mx_pkg::mx_in_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output mx_pkg::mx_out_t rsp
);
  import mx_pkg::*;

  mx_stat_t stat;
  mx_out_t  core_res;
  logic     take;

  // core is free for a new request only when idle
  assign req_ready = stat.idle;

  // response register accepts when empty or being drained
  assign take = stat.done && (!rsp_valid || rsp_ready);

  mx_core #(.W(OPERAND_WIDTH)) u_core (
    .clk   (clk),
    .rst   (rst),
    .start (req_valid && req_ready),
    .req   (req),
    .take  (take),
    .stat  (stat),
    .res   (core_res)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        rsp_valid <= 1'b1;
        rsp       <= core_res;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/mx_checker.sv @@
// ----------------------------------------------------------------------------
// mx_checker
// Port-level checks for modular_exponentiation, attached by bind.
// ----------------------------------------------------------------------------
module mx_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input mx_pkg::mx_in_t  req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input mx_pkg::mx_out_t rsp
);
  import mx_pkg::*;

  // a waiting request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // nothing left over after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // an error response carries a zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_modulus |-> rsp.power_result == '0)
    else $error("bad modulus with nonzero result");

  // a taken request keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a request is in work");

endmodule

bind modular_exponentiation mx_checker u_mx_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

@@ tb/modular_exponentiation_tb.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the square-and-multiply exponentiation block.
// A clocked driver feeds requests from a backlog, a clocked monitor checks
// each response against a bit-true power predictor, and the response side
// is throttled at random, with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mx_pkg::*;

  localparam logic [DATA_W-1:0] ALL1    = '1;
  localparam logic [DATA_W-1:0] PRIME64 = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [DATA_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;
  localparam int N_RANDOM     = 80;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 40000;
  localparam int TAIL_CYCLES  = 50;
  localparam int RUN_LIMIT    = 8000000;

  // backlog entry: a request, or a marker to wait for all responses
  typedef struct {
    mx_in_t args;
    bit     drain;
  } backlog_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    req_valid = 1'b0;
  logic    req_ready;
  mx_in_t  req = '0;
  logic    rsp_valid;
  logic    rsp_ready = 1'b0;
  mx_out_t rsp;

  backlog_t req_backlog[$];
  mx_out_t  due_results[$];
  int       total_reqs = 0;
  int       n_accepted = 0;
  int       n_results = 0;
  int       fail_count = 0;
  int       cycle_count = 0;
  int       hold_left = 0;
  bit       hold_used = 1'b0;
  int       send_idle_pct;
  int       recv_idle_pct;

  modular_exponentiation dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // (x + y) mod m for residues x, y; a carry out of 64 bits also subtracts
  function automatic logic [DATA_W-1:0] mod_add(logic [DATA_W-1:0] x,
                                                logic [DATA_W-1:0] y,
                                                logic [DATA_W-1:0] m);
    logic [DATA_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s[DATA_W] || s[DATA_W-1:0] >= m) s[DATA_W-1:0] = s[DATA_W-1:0] - m;
    return s[DATA_W-1:0];
  endfunction

  // (x * y) mod m by shift-and-add over every bit of y
  function automatic logic [DATA_W-1:0] mod_mul(logic [DATA_W-1:0] x,
                                                logic [DATA_W-1:0] y,
                                                logic [DATA_W-1:0] m);
    logic [DATA_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (y[i]) acc = mod_add(acc, x, m);
      x = mod_add(x, x, m);
    end
    return acc;
  endfunction

  // base ^ exponent mod modulus, right-to-left over the exponent bits
  function automatic mx_out_t mod_power(mx_in_t a);
    mx_out_t r;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] acc;
    r = '0;
    if (a.modulus == '0) begin
      r.bad_modulus = 1'b1;
      return r;
    end
    acc = 64'd1;
    if (a.exponent != '0) begin
      b = a.base % a.modulus;
      for (int i = 0; i < DATA_W; i++) begin
        if (a.exponent[i]) acc = mod_mul(b, acc, a.modulus);
        b = mod_mul(b, b, a.modulus);
      end
    end
    r.power_result = acc;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_req(logic [DATA_W-1:0] b, logic [DATA_W-1:0] e,
                         logic [DATA_W-1:0] m);
    backlog_t p;
    p.args.base = b;
    p.args.exponent = e;
    p.args.modulus = m;
    p.drain = 1'b0;
    req_backlog.push_back(p);
    total_reqs++;
  endtask

  task automatic flag_mismatch(string what);
    $display("[%0d] mismatch: %s", cycle_count, what);
    fail_count++;
  endtask

  // idle rates by progress: sender-light, then receiver-light, then none
  always_comb begin
    if (n_accepted < total_reqs / 3) begin
      send_idle_pct = 36;
      recv_idle_pct = 57;
    end else if (n_accepted < 2 * total_reqs / 3) begin
      send_idle_pct = 57;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // request driver, predicts each accepted request
  always @(posedge clk) begin : driver
    bit fire;
    bit offer;
    fire = req_valid && req_ready;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (fire) begin
        due_results.push_back(mod_power(req));
        n_accepted <= n_accepted + 1;
      end
      if (!req_valid || fire) begin
        // pause marker: hold back until every response is in
        if (!fire && req_backlog.size() != 0 && req_backlog[0].drain &&
            due_results.size() == 0)
          void'(req_backlog.pop_front());
        offer = req_backlog.size() != 0 && !req_backlog[0].drain &&
                $urandom_range(99) >= send_idle_pct;
        if (offer) begin
          req <= req_backlog[0].args;
          void'(req_backlog.pop_front());
        end
        req_valid <= offer;
      end
    end
  end

  // long response hold-off, once, so the block backs up its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && n_results == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // response ready
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
  end

  // response monitor
  always @(posedge clk) begin : monitor
    mx_out_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_results.size() == 0) begin
        flag_mismatch("response with no request outstanding");
      end else begin
        want = due_results.pop_front();
        if (rsp.power_result !== want.power_result)
          flag_mismatch($sformatf("power_result %h, expected %h",
                                  rsp.power_result, want.power_result));
        if (rsp.bad_modulus !== want.bad_modulus)
          flag_mismatch($sformatf("bad_modulus %b, expected %b",
                                  rsp.bad_modulus, want.bad_modulus));
      end
      n_results <= n_results + 1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    backlog_t marker;
    int r;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] e;
    logic [DATA_W-1:0] m;

    // zero modulus
    add_req(64'd5, 64'd3, '0);
    add_req(ALL1, ALL1, '0);
    add_req('0, '0, '0);
    // zero exponent gives one, even for modulus one
    add_req(64'd7, '0, 64'd1);
    add_req(ALL1, '0, ALL1);
    add_req('0, '0, 64'd13);
    // modulus one
    add_req(64'd9, 64'd5, 64'd1);
    // zero base and bases that reduce to zero
    add_req('0, ALL1, ALL1);
    add_req(ALL1, ALL1, ALL1);
    // residues near 2^64, sums carry out
    add_req(ALL1 - 1, ALL1, ALL1);
    add_req(ALL1, ALL1, PRIME64);
    add_req(64'd2, 64'd64, PRIME64);
    add_req(TOP_BIT, 64'hAAAA_AAAA_AAAA_AAAA, TOP_BIT + 1);
    add_req(ALL1, 64'd2, TOP_BIT);
    add_req(64'd3, TOP_BIT, PRIME64);
    // small plain cases, base below and above the modulus
    add_req(64'd3, 64'd1, 64'd7);
    add_req(64'd100, 64'd1, 64'd7);
    add_req(64'd2, 64'd10, 64'd1000);
    add_req(ALL1, 64'd1, 64'd2);
    add_req(64'd1, ALL1, 64'd3);

    marker.args = '0;
    marker.drain = 1'b1;
    req_backlog.push_back(marker);

    // random part: mostly short exponents, a few full-width
    for (int k = 0; k < N_RANDOM; k++) begin
      r = $urandom_range(99);
      if (r < 4) m = '0;
      else if (r < 8) m = 64'd1;
      else if (r < 20) m = ALL1 >> $urandom_range(3);
      else m = rand64() >> $urandom_range(63);
      b = ($urandom_range(1) != 0) ? rand64() : rand64() >> $urandom_range(63);
      r = $urandom_range(99);
      if (r < 12) e = rand64();
      else if (r < 17) e = '0;
      else e = rand64() >> $urandom_range(48, 63);
      add_req(b, e, m);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || req_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
sv/mx_pkg.sv
sv/mx_addmod.sv
sv/mx_core.sv
sv/modular_exponentiation.sv
sv/mx_checker.sv
tb/modular_exponentiation_tb.sv
